// File: rtl/fqd_pkg.sv
// Shared constants and types for the FIFO queue with delete.
// Holds operation and status codes and the result control struct.
// No dependencies.
`default_nettype none

package fqd_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] OP_ENQ = 2'd0;
   localparam logic [FUNC_W-1:0] OP_DEQ = 2'd1;
   localparam logic [FUNC_W-1:0] OP_DEL = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      logic                done;
      logic [STATUS_W-1:0] status;
   } res_ctl_type;

endpackage

`default_nettype wire

// File: rtl/fifo_queue_with_delete.sv
// Enqueue and requests rejected on acceptance are answered without a store read;
// dequeue reads via S_DEQ; delete scans in S_SCAN, shifts later entries in S_SHIFT.
// Throughput: one enqueue per cycle while the response slot is free; dequeue
// and delete hold the request side until done, set by the store's single read port.
// Reset clears state, head, count and the response valid flag; the store is not cleared.
`default_nettype none

module fifo_queue_with_delete #(
   parameter int DEPTH      = fqd_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = fqd_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire logic                                           req_tvalid,
   output logic                                                req_tready,
   // item_value
   input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]                req_tdata,
   // func
   input  wire logic [fqd_pkg::FUNC_W-1:0]                     req_tuser,
   output logic                                                rsp_tvalid,
   input  wire logic                                           rsp_tready,
   // out_value, length
   output logic [((DATA_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0]     rsp_tdata,
   // status
   output logic [fqd_pkg::STATUS_W-1:0]                        rsp_tuser
);

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int RDW = ((DATA_WIDTH + CW + 7) / 8) * 8;

   fqd_pkg::res_ctl_type         res_ctl;
   logic [DATA_WIDTH-1:0]        res_value;
   logic [CW-1:0]                res_length;
   logic                         slot_free;

   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [DATA_WIDTH-1:0]        wr_data;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic [DATA_WIDTH-1:0]        rd_data;

   logic                         rsp_valid_ff;
   logic [fqd_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [DATA_WIDTH-1:0]        rsp_value_ff;
   logic [CW-1:0]                rsp_length_ff;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   fqd_seq #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_func   (req_tuser),
      .req_word   (req_tdata[DATA_WIDTH-1:0]),
      .slot_free  (slot_free),
      .res_ctl    (res_ctl),
      .res_value  (res_value),
      .res_length (res_length),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   fqd_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ctl.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_ctl.done) begin
         rsp_status_ff <= res_ctl.status;
         rsp_value_ff  <= res_value;
         rsp_length_ff <= res_length;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RDW'({rsp_length_ff, rsp_value_ff});

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !res_ctl.done)
      else $error("response overwritten while stalled");

   a_enq_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == fqd_pkg::OP_ENQ) |=> rsp_valid_ff)
      else $error("enqueue response missing");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_length_ff <= CW'(DEPTH)))
      else $error("length beyond depth");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == fqd_pkg::ST_FULL) |-> (rsp_length_ff == CW'(DEPTH)))
      else $error("full status with room left");

endmodule

`default_nettype wire

// File: rtl/fqd_ram.sv
// Entry store: one write port, one read port, registered read data.
// Uses no package items.
`default_nettype none

module fqd_ram #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0]    wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/fqd_seq.sv
// Operation sequencer: head and count registers, scan and shift for delete.
// Depends on fqd_pkg; drives the ports of fqd_ram.
`default_nettype none

module fqd_seq #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [fqd_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [DATA_WIDTH-1:0]         req_word,
   input  wire logic                          slot_free,
   output fqd_pkg::res_ctl_type               res_ctl,
   output logic      [DATA_WIDTH-1:0]         res_value,
   output logic      [$clog2(DEPTH+1)-1:0]    res_length,
   output logic                               wr_en,
   output logic      [$clog2(DEPTH)-1:0]      wr_addr,
   output logic      [DATA_WIDTH-1:0]         wr_data,
   output logic                               rd_en,
   output logic      [$clog2(DEPTH)-1:0]      rd_addr,
   input  wire logic [DATA_WIDTH-1:0]         rd_data
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SUM_W = AW + 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_DEQ   = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_SHIFT = 2'd3;

   logic [1:0]            state_ff,  state_in;
   logic [AW-1:0]         head_ff,   head_in;
   logic [CW-1:0]         count_ff,  count_in;
   logic [AW-1:0]         idx_ff,    idx_in;
   logic [DATA_WIDTH-1:0] word_ff,   word_in;

   logic          accept;
   logic [AW-1:0] last_idx;
   logic [AW-1:0] idx_p1;
   logic [AW-1:0] idx_p2;
   logic [CW-1:0] count_m1;
   logic [CW-1:0] count_p1;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [AW-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, head} + {1'b0, off};
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign count_m1  = count_ff - CW'(1);
   assign count_p1  = count_ff + CW'(1);
   assign last_idx  = count_m1[AW-1:0];
   assign idx_p1    = idx_ff + AW'(1);
   assign idx_p2    = idx_ff + AW'(2);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      word_in    = word_ff;
      res_ctl    = '{done: 1'b0, status: fqd_pkg::ST_REJECT};
      res_value  = '0;
      res_length = count_ff;
      wr_en      = 1'b0;
      wr_addr    = slot_of(head_ff, count_ff[AW-1:0]);
      wr_data    = req_word;
      rd_en      = 1'b0;
      rd_addr    = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  fqd_pkg::OP_ENQ: begin
                     res_ctl.done = 1'b1;
                     if (req_word == '0) begin
                        res_ctl.status = fqd_pkg::ST_REJECT;
                     end else if (count_ff == CW'(DEPTH)) begin
                        res_ctl.status = fqd_pkg::ST_FULL;
                     end else begin
                        wr_en          = 1'b1;
                        count_in       = count_p1;
                        res_ctl.status = fqd_pkg::ST_OK;
                        res_length     = count_p1;
                     end
                  end
                  fqd_pkg::OP_DEQ: begin
                     if (count_ff == '0) begin
                        res_ctl.done = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        head_in  = slot_of(head_ff, AW'(1));
                        count_in = count_m1;
                        state_in = S_DEQ;
                     end
                  end
                  fqd_pkg::OP_DEL: begin
                     if (req_word == '0 || count_ff == '0) begin
                        res_ctl.done = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        idx_in   = '0;
                        word_in  = req_word;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     res_ctl.done = 1'b1;
                  end
               endcase
            end
         end
         S_DEQ: begin
            res_ctl    = '{done: 1'b1, status: fqd_pkg::ST_OK};
            res_value  = rd_data;
            state_in   = S_IDLE;
         end
         S_SCAN: begin
            if (rd_data == word_ff) begin
               if (idx_ff == last_idx) begin
                  res_ctl    = '{done: 1'b1, status: fqd_pkg::ST_OK};
                  count_in   = count_m1;
                  res_length = count_m1;
                  state_in   = S_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = slot_of(head_ff, idx_p1);
                  state_in = S_SHIFT;
               end
            end else if (idx_ff == last_idx) begin
               res_ctl  = '{done: 1'b1, status: fqd_pkg::ST_REJECT};
               state_in = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = slot_of(head_ff, idx_p1);
               idx_in  = idx_p1;
            end
         end
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head_ff, idx_ff);
            wr_data = rd_data;
            if (idx_p1 == last_idx) begin
               res_ctl    = '{done: 1'b1, status: fqd_pkg::ST_OK};
               count_in   = count_m1;
               res_length = count_m1;
               state_in   = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = slot_of(head_ff, idx_p2);
               idx_in  = idx_p1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      idx_ff  <= idx_in;
      word_ff <= word_in;
   end

endmodule

`default_nettype wire

// File: verif/fifo_queue_with_delete_test.sv
// Self-checking testbench for fifo_queue_with_delete: drives request transactions,
// expects shadow-queue predictions or fixed directed responses, compares in order.
// Depends on fqd_pkg and the fifo_queue_with_delete RTL only.
module fifo_queue_with_delete_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QDEPTH       = 16;
   localparam int WORD_W       = 32;
   localparam int LEN_W        = $clog2(QDEPTH + 1);
   localparam int RSP_W        = ((WORD_W + LEN_W + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 1250;
   localparam logic [fqd_pkg::FUNC_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [fqd_pkg::STATUS_W-1:0] status;
      logic [WORD_W-1:0]            word;
      logic [LEN_W-1:0]             count;
   } queue_rsp_type;

   typedef struct {
      logic [fqd_pkg::FUNC_W-1:0] func;
      logic [WORD_W-1:0]          value;
      bit                         typed;
      queue_rsp_type              rsp;
   } stim_row_type;

   logic clock      = 1'b0;
   logic reset      = 1'b1;
   logic req_tvalid = 1'b0;
   logic rsp_tready = 1'b0;
   logic req_tready;
   logic rsp_tvalid;
   logic [WORD_W-1:0]            req_tdata = '0;
   logic [fqd_pkg::FUNC_W-1:0]   req_tuser = fqd_pkg::OP_ENQ;
   logic [RSP_W-1:0]             rsp_tdata;
   logic [fqd_pkg::STATUS_W-1:0] rsp_tuser;

   logic [WORD_W-1:0] shadow_q[$];
   queue_rsp_type     pending_rsp[$];
   stim_row_type      directed_rows[$];
   int send_idle_pct = 20;
   int recv_idle_pct = 82;
   int errors        = 0;
   int full_seen     = 0;
   int rsp_seen      = 0;
   int op_count[4]   = '{default: 0};

   fifo_queue_with_delete #(
      .DEPTH      (QDEPTH),
      .DATA_WIDTH (WORD_W)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
      $display("fifo_queue_with_delete_test NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic queue_rsp_type apply_queue_op(
         input logic [fqd_pkg::FUNC_W-1:0] func,
         input logic [WORD_W-1:0]          value);
      queue_rsp_type r;
      int            hit;
      r.status = fqd_pkg::ST_REJECT;
      r.word   = '0;
      hit      = -1;
      case (func)
         fqd_pkg::OP_ENQ: begin
            if (value == '0)
               r.status = fqd_pkg::ST_REJECT;
            else if (shadow_q.size() >= QDEPTH)
               r.status = fqd_pkg::ST_FULL;
            else begin
               shadow_q.push_back(value);
               r.status = fqd_pkg::ST_OK;
            end
         end
         fqd_pkg::OP_DEQ: begin
            if (shadow_q.size() != 0) begin
               r.word   = shadow_q.pop_front();
               r.status = fqd_pkg::ST_OK;
            end
         end
         fqd_pkg::OP_DEL: begin
            if (value != '0) begin
               foreach (shadow_q[i])
                  if (hit < 0 && shadow_q[i] == value) hit = i;
               if (hit >= 0) begin
                  shadow_q.delete(hit);
                  r.status = fqd_pkg::ST_OK;
               end
            end
         end
         default: ;
      endcase
      r.count = LEN_W'(shadow_q.size());
      return r;
   endfunction

   function automatic stim_row_type random_row(input int mode);
      stim_row_type row;
      int           pick;
      int           vsel;
      pick      = $urandom_range(99);
      vsel      = $urandom_range(99);
      row.typed = 1'b0;
      row.rsp   = '0;
      if (pick < 5)
         row.func = OP_UNUSED;
      else if (pick < (mode == 0 ? 65 : mode == 1 ? 30 : 45))
         row.func = fqd_pkg::OP_ENQ;
      else if (pick < (mode == 0 ? 80 : mode == 1 ? 70 : 72))
         row.func = fqd_pkg::OP_DEQ;
      else
         row.func = fqd_pkg::OP_DEL;
      if (vsel < 6)
         row.value = '0;
      else if (row.func == fqd_pkg::OP_DEL && shadow_q.size() != 0 && vsel < 66)
         row.value = shadow_q[$urandom_range(shadow_q.size() - 1)];
      else if (vsel < 70)
         row.value = WORD_W'($urandom_range(8, 1));
      else if (vsel < 80)
         row.value = vsel[0] ? '1 : {1'b1, {(WORD_W-1){1'b0}}};
      else
         row.value = $urandom;
      return row;
   endfunction

   task automatic add_row(input logic [fqd_pkg::FUNC_W-1:0]   func,
                          input logic [WORD_W-1:0]            value,
                          input bit                           typed,
                          input logic [fqd_pkg::STATUS_W-1:0] status,
                          input logic [WORD_W-1:0]            word,
                          input int                           count);
      stim_row_type row;
      row.func  = func;
      row.value = value;
      row.typed = typed;
      row.rsp   = '{status: status, word: word, count: LEN_W'(count)};
      directed_rows.push_back(row);
   endtask

   task automatic send_req(input stim_row_type row);
      queue_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      predicted = apply_queue_op(row.func, row.value);
      pending_rsp.push_back(row.typed ? row.rsp : predicted);
      op_count[row.func]++;
      req_tvalid <= 1'b1;
      req_tuser  <= row.func;
      req_tdata  <= row.value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      queue_rsp_type want;
      queue_rsp_type got;
      bit            bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen++;
         got = '{status: rsp_tuser, word: rsp_tdata[WORD_W-1:0],
                 count: rsp_tdata[WORD_W +: LEN_W]};
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction: status %0d word %h length %0d",
                     $time, got.status, got.word, got.count);
         end else begin
            want = pending_rsp.pop_front();
            bad  = 1'b0;
            if (got.status !== want.status) begin
               bad = 1'b1;
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, want.status, got.status);
            end
            if (got.word !== want.word) begin
               bad = 1'b1;
               $display("%0t: out_value mismatch: expected %h actual %h",
                        $time, want.word, got.word);
            end
            if (got.count !== want.count) begin
               bad = 1'b1;
               $display("%0t: length mismatch: expected %0d actual %0d",
                        $time, want.count, got.count);
            end
            if (bad) errors++;
            if (want.status == fqd_pkg::ST_FULL) full_seen++;
         end
      end
   end

   initial begin
      int phase;
      int mode;
      add_row(fqd_pkg::OP_DEQ, 32'h0000_0000, 1'b1, fqd_pkg::ST_REJECT, '0, 0);
      add_row(fqd_pkg::OP_DEL, 32'h1234_5678, 1'b1, fqd_pkg::ST_REJECT, '0, 0);
      add_row(fqd_pkg::OP_ENQ, 32'h0000_0000, 1'b1, fqd_pkg::ST_REJECT, '0, 0);
      add_row(OP_UNUSED,       '1,            1'b1, fqd_pkg::ST_REJECT, '0, 0);
      add_row(fqd_pkg::OP_ENQ, '1,            1'b1, fqd_pkg::ST_OK,     '0, 1);
      add_row(fqd_pkg::OP_ENQ, 32'h0000_0001, 1'b1, fqd_pkg::ST_OK,     '0, 2);
      add_row(fqd_pkg::OP_DEL, 32'h0000_0000, 1'b1, fqd_pkg::ST_REJECT, '0, 2);
      add_row(fqd_pkg::OP_DEL, 32'h0000_0007, 1'b1, fqd_pkg::ST_REJECT, '0, 2);
      add_row(fqd_pkg::OP_DEQ, '1,            1'b1, fqd_pkg::ST_OK,     '1, 1);
      for (int i = 0; i < QDEPTH - 1; i++)
         add_row(fqd_pkg::OP_ENQ, i == 7 ? 32'h8000_0000 : WORD_W'(i % 5 + 2), 1'b0,
                 fqd_pkg::ST_OK, '0, 0);
      add_row(fqd_pkg::OP_ENQ, 32'h0000_00AA, 1'b1, fqd_pkg::ST_FULL,   '0, QDEPTH);
      add_row(fqd_pkg::OP_DEL, 32'h0000_0004, 1'b0, fqd_pkg::ST_OK,     '0, 0);
      add_row(fqd_pkg::OP_DEQ, 32'h0000_0000, 1'b0, fqd_pkg::ST_OK,     '0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) send_req(directed_rows[i]);

      phase = 0;
      mode  = 2;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) mode = $urandom_range(2);
         if (n * 3 / RANDOM_ITEMS != phase || $urandom_range(199) == 0) begin
            phase = n * 3 / RANDOM_ITEMS;
            hold_until_drained();
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 82 : 0;
            recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 20 : 0;
         end
         send_req(random_row(mode));
      end
      hold_until_drained();
      repeat (40) @(posedge clock);

      $display("ran %0d enqueue, %0d dequeue, %0d delete and %0d unused-code requests",
               op_count[fqd_pkg::OP_ENQ], op_count[fqd_pkg::OP_DEQ],
               op_count[fqd_pkg::OP_DEL], op_count[OP_UNUSED]);
      $display("checked %0d responses, %0d of them full-queue drops, %0d errors",
               rsp_seen, full_seen, errors);
      if (errors == 0)
         $display("fifo_queue_with_delete_test OK");
      else
         $display("fifo_queue_with_delete_test NOT OK");
      $finish;
   end
endmodule

// File: sim.f
rtl/fqd_pkg.sv
rtl/fqd_ram.sv
rtl/fqd_seq.sv
rtl/fifo_queue_with_delete.sv
verif/fifo_queue_with_delete_test.sv
